>>> design/blid_pkg.sv
package blid_pkg;

   // Count/index width carried in the cell command; covers a list of up to 127 entries
   localparam int CNT_W = 7;

   // Request kinds
   localparam logic [1:0] KIND_FRONT  = 2'd0;
   localparam logic [1:0] KIND_BACK   = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic [15:0]        position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic               is_last;
      logic               list_empty;
      logic               insert_dropped;
   } rsp_type;

   // Operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_FRONT,
      CMD_BACK,
      CMD_DELETE,
      CMD_ROTATE
   } cmd_mode_type;

   typedef struct packed {
      cmd_mode_type       mode;
      logic signed [31:0] value;
      logic [CNT_W-1:0]   pos;
      logic [CNT_W-1:0]   count;
   } cmd_type;

endpackage

>>> design/bounded_list_insert_delete_dump.sv
// Each accepted request moves the control to the dump state, which registers its results:
// max(N,1) results, N being the entry count after the request, one dumped entry per
// cycle while the cell chain rotates the list past its head.
// A stalled result holds the dump; the next request is taken once the dump is over.
// Reset clears the entry count and the control state; cell contents stay undefined
// and are never shown before they are written.
module bounded_list_insert_delete_dump #(
   parameter int CAPACITY = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  blid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output blid_pkg::rsp_type rsp_data
);
   import blid_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               slot_free;
   logic               pos_ok;
   logic               full;
   cmd_type            cmd;
   logic signed [31:0] cell_data [CAPACITY];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff == CW'(CAPACITY));
   assign pos_ok    = (req_data.position < 16'(count_ff));

   // command to the chain and control next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd.mode     = CMD_HOLD;
      cmd.value    = req_data.value;
      cmd.pos      = CNT_W'(req_data.position);
      cmd.count    = CNT_W'(count_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               dropped_in = 1'b0;
               case (req_data.kind)
                  KIND_FRONT, KIND_BACK: begin
                     if (full) begin
                        dropped_in = 1'b1;
                     end else begin
                        cmd.mode = (req_data.kind == KIND_FRONT) ? CMD_FRONT : CMD_BACK;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_DELETE: begin
                     if (pos_ok) begin
                        cmd.mode = CMD_DELETE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: cmd.mode = CMD_HOLD;
               endcase
               rem_in   = count_in;
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.element        = (count_ff == '0) ? '0 : cell_data[0];
               rsp_data_in.is_last        = (rem_ff <= CW'(1));
               rsp_data_in.list_empty     = (count_ff == '0);
               rsp_data_in.insert_dropped = dropped_ff;
               if (count_ff != '0) begin
                  cmd.mode = CMD_ROTATE;
                  rem_in   = rem_ff - 1'b1;
               end
               if (rem_ff <= CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // chain of entry cells, front at cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_d;
      logic signed [31:0] right_d;
      if (i == 0) begin : g_left_edge
         assign left_d = req_data.value;
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_right_edge
         assign right_d = cell_data[0];
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end
      blid_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .first_data (cell_data[0]),
         .data       (cell_data[i])
      );
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_req_to_dump: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_DUMP)
      else $error("request transfer did not start a dump");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> rem_ff <= count_ff)
      else $error("dump counter beyond entry count");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.list_empty |-> rsp_data_ff.is_last)
      else $error("empty result not marked last");
`endif

endmodule

>>> design/blid_cell.sv
module blid_cell #(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  blid_pkg::cmd_type       cmd,
   input  logic signed [31:0]      left_data,
   input  logic signed [31:0]      right_data,
   input  logic signed [31:0]      first_data,
   output logic signed [31:0]      data
);
   import blid_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   // next value chosen from the broadcast command and the neighbors
   always_comb begin
      data_in = data_ff;
      unique case (cmd.mode)
         CMD_HOLD:   data_in = data_ff;
         CMD_FRONT:  data_in = (MY_IDX == '0) ? cmd.value : left_data;
         CMD_BACK:   data_in = (MY_IDX == cmd.count) ? cmd.value : data_ff;
         CMD_DELETE: data_in = (MY_IDX >= cmd.pos) ? right_data : data_ff;
         CMD_ROTATE: data_in = (MY_NEXT == cmd.count) ? first_data : right_data;
         default:    data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
